@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/fsrt_pkg.sv @@
`default_nettype none
package fsrt_pkg;

    // Table depth and index width
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd120;

    // Input transaction payload
    typedef struct packed {
        logic [63:0]        addr_high;
        logic [63:0]        addr_low;
        logic [15:0]        client_port;
        logic signed [31:0] sequence_req;
        logic [31:0]        now_seconds;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic               reordered;
        logic signed [31:0] stored_sequence;
        logic               new_flow;
        logic               table_full;
    } out_t;

    // One stored flow
    typedef struct packed {
        logic [63:0]        addr_high;
        logic [63:0]        addr_low;
        logic [15:0]        port;
        logic signed [31:0] sequence_num;
        logic [31:0]        time_sec;
    } entry_t;

    // Verdict of the compare unit for one entry
    typedef struct packed {
        logic match;
        logic stale;
        logic reorder;
        logic wr_en;
    } scan_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

@@ sv/flow_sequence_reorder_tracker_unit.sv @@
// Steps: accept in ST_IDLE, scan all entries in ST_SCAN, then ST_DRAIN and ST_FINISH,
// which registers the result once the output is free. One transaction at a time; the scan
// reads one table entry per cycle through the single read port of the entry RAM.
// Reset (aresetn low, synchronous): all entries invalid, timeout back to 120 s,
// sequencer idle, no result pending. Entry contents are not cleared.
`default_nettype none
module flow_sequence_reorder_tracker_unit
    import fsrt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               pv_reg, pv_next;
    in_t                item_reg, item_next;
    logic [15:0]        timeout_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               found_reg, found_next;
    logic               reord_reg, reord_next;
    logic signed [31:0] stored_reg, stored_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    out_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;
    logic             ram_rd_en;
    entry_t           ram_rd_data;
    scan_res_t        res;
    entry_t           upd_data;
    entry_t           new_entry;
    logic             out_free;

    fsrt_entry_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    fsrt_scan_unit u_scan (
        .entry_valid (valid_reg[pidx_reg]),
        .entry       (ram_rd_data),
        .item        (item_reg),
        .timeout     (timeout_reg),
        .res         (res),
        .wr_data     (upd_data)
    );

    // No transaction is taken while reset is held
    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = aresetn;
    assign out_free  = !m_valid_reg || m_ready;

    // Entry written for a new flow
    always_comb begin
        new_entry.addr_high    = item_reg.addr_high;
        new_entry.addr_low     = item_reg.addr_low;
        new_entry.port         = item_reg.client_port;
        new_entry.sequence_num = item_reg.sequence_req;
        new_entry.time_sec     = item_reg.now_seconds;
    end

    // Sequencer: next state, scan bookkeeping, write port, result
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        pv_next         = 1'b0;
        item_next       = item_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        reord_next      = reord_reg;
        stored_next     = stored_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pidx_reg;
        ram_wr_data     = upd_data;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Entry read last cycle: age, compare, write back
        if (pv_reg) begin
            ram_wr_en = res.wr_en;
            if (!valid_reg[pidx_reg]) begin
                if (!free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = pidx_reg;
                end
            end else if (res.match) begin
                if (!found_reg) begin
                    stored_next = ram_rd_data.sequence_num;
                end
                found_next = 1'b1;
                if (res.reorder) begin
                    reord_next = 1'b1;
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    reord_next      = 1'b0;
                    stored_next     = 32'sd0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_rd_en = 1'b1;
                pv_next   = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next.reordered       = reord_reg;
                    out_next.stored_sequence = found_reg ? stored_reg : 32'sd0;
                    out_next.new_flow        = !found_reg;
                    out_next.table_full      = !found_reg && !free_found_reg;
                    m_valid_next             = 1'b1;
                    if (!found_reg && free_found_reg) begin
                        ram_wr_en                 = 1'b1;
                        ram_wr_addr               = free_idx_reg;
                        ram_wr_data               = new_entry;
                        valid_next[free_idx_reg]  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pv_reg      <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            state_reg   <= state_next;
            pv_reg      <= pv_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Payload and scan accumulators
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        item_reg       <= item_next;
        found_reg      <= found_next;
        reord_reg      <= reord_next;
        stored_reg     <= stored_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        out_reg        <= out_next;
    end

endmodule
`default_nettype wire

@@ sv/fsrt_entry_ram.sv @@
`default_nettype none
module fsrt_entry_ram
    import fsrt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [ENTRIES];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/fsrt_scan_unit.sv @@
`default_nettype none
module fsrt_scan_unit
    import fsrt_pkg::*;
(
    input  wire logic        entry_valid,
    input  wire entry_t      entry,
    input  wire in_t         item,
    input  wire logic [15:0] timeout,
    output scan_res_t        res,
    output entry_t           wr_data
);

    logic [31:0] age;
    logic        key_eq;

    // Age modulo 2^32 against the timeout, key compare
    always_comb begin
        age    = item.now_seconds - entry.time_sec;
        key_eq = (entry.addr_high == item.addr_high) &&
                 (entry.addr_low == item.addr_low) &&
                 (entry.port == item.client_port);

        res.stale   = entry_valid && (age >= {16'd0, timeout});
        res.match   = entry_valid && key_eq;
        res.reorder = res.match && !res.stale &&
                      (entry.sequence_num > item.sequence_req);
        res.wr_en   = res.match ? !res.reorder : res.stale;
    end

    // Updated entry: a match takes the new sequence, a stale one goes to zero
    always_comb begin
        wr_data              = entry;
        wr_data.sequence_num = res.match ? item.sequence_req : 32'sd0;
        wr_data.time_sec     = item.now_seconds;
    end

endmodule
`default_nettype wire

@@ sv/fsrt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module fsrt_checker
    import fsrt_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire in_t         s_data,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire out_t        m_data,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [15:0] cfg_data
);

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // One transaction at a time: not ready right after an accept
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A refused flow is always a new flow
    `ASSERT_SAME(a_full_is_new, aclk, aresetn, m_valid && m_data.table_full, m_data.new_flow)

    // A new flow reports no stored sequence and no reorder
    `ASSERT_SAME(a_new_clean, aclk, aresetn, m_valid && m_data.new_flow,
        (m_data.stored_sequence == 32'sd0) && !m_data.reordered)

endmodule

bind flow_sequence_reorder_tracker_unit fsrt_checker u_fsrt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
`default_nettype wire
